// File: hw/rtl/sorted_table_binary_search_unit_defines.svh
// assertion macros for the sorted table binary search unit
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// clocked check, disabled while reset is asserted
`ifndef SYNTHESIS
`define SBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`else
`define SBS_ASSERT(lbl, prop, msg)
`endif

// clocked check that also holds during reset
`ifndef SYNTHESIS
`define SBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/sbs_pkg.sv
// types, constants and probe step logic shared by the binary search unit
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

  // table geometry
  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COUNT_W   = 9;
  localparam int SLOT_W    = 8;
  localparam int POS_W     = 8;
  localparam int DATA_W    = 32;
  // one cell for the first entry, one for the last, then the bisection steps
  localparam int NUM_CELLS = 2 + $clog2(DEPTH - 1);

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // probe phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_LAST   = 2'd1;
  localparam logic [1:0] PH_BISECT = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     probed;
    logic [1:0]               phase;
    logic                     done;
    logic                     hit;
    logic [ADDR_W-1:0]        pos;
    logic [ADDR_W-1:0]        lo;
    logic [ADDR_W-1:0]        hi;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] key;
  } probe_t;

  // settle the previous probe, then pick the next address to read
  function automatic probe_t probe_resolve(probe_t s, logic signed [DATA_W-1:0] rd);
    probe_t r;
    r = s;
    if (s.valid && s.probed && !s.done) begin
      if (rd == s.key) begin
        r.done = 1'b1;
        r.hit  = 1'b1;
        r.pos  = s.addr;
      end else begin
        case (s.phase)
          PH_FIRST: r.phase = PH_LAST;
          PH_LAST:  r.phase = PH_BISECT;
          PH_BISECT: begin
            if (rd > s.key) r.hi = s.addr;
            else            r.lo = s.addr;
          end
          default: r.done = 1'b1;
        endcase
        // bounds adjacent: nothing left between them
        if (s.phase != PH_FIRST && (r.hi - r.lo) <= ADDR_W'(1)) r.done = 1'b1;
      end
    end
    r.probed = 1'b1;
    case (r.phase)
      PH_FIRST:  r.addr = r.lo;
      PH_LAST:   r.addr = r.hi;
      PH_BISECT: r.addr = r.lo + ((r.hi - r.lo) >> 1);
      default:   r.addr = r.lo;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sbs_cell.sv
// one search cell: settles the upstream probe and reads its own table copy
`timescale 1ns / 1ps
`default_nettype none

module sbs_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sbs_pkg::wr_t                     wr_i,
  input  wire sbs_pkg::probe_t                  prev_i,
  input  wire logic signed [sbs_pkg::DATA_W-1:0] prev_rdata_i,
  output      sbs_pkg::probe_t                  state_o,
  output      logic signed [sbs_pkg::DATA_W-1:0] rdata_o
);
  import sbs_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  probe_t            nxt;
  probe_t            state_q;
  logic              valid_q;
  logic [DATA_W-1:0] rdata_q;

  // step the search by one probe
  assign nxt = probe_resolve(prev_i, prev_rdata_i);

  // local copy of the table
  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem_q[wr_i.addr] <= wr_i.data;
    rdata_q <= mem_q[nxt.addr];
  end

  // handoff control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  // handoff payload
  always_ff @(posedge clk_i) begin
    state_q <= nxt;
  end

  always_comb begin
    state_o       = state_q;
    state_o.valid = valid_q;
  end

  assign rdata_o = signed'(rdata_q);

endmodule

`default_nettype wire

// File: hw/rtl/sorted_table_binary_search_unit.sv
// top level of the sorted table binary search unit
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_binary_search_unit_defines.svh"

// Binary search over a table of up to 256 ascending signed 32-bit entries.
// A load word writes one entry and gives no result. A search word runs
// through a row of 10 cells: the first checks entry 0, the second the last
// entry in use, and each of the other eight does one bisection probe; every
// cell reads its own copy of the table through one registered read port. The
// result passes the cell registers into the output register, and the next
// word is taken once the result has left the row and the skid stage is empty.
// Only one word is in flight at a time. An output skid stage lets a finished
// result wait without losing the next one. entry_count (reset 1) is written
// through cfg_we_i / cfg_wdata_i, by the user only while idle (the block does
// not enforce it); 0 acts as 1 and values above 256 act as 256. Entries never
// loaded read back as undefined. There is no clearing pass after reset.
module sorted_table_binary_search_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbs_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire sbs_pkg::req_t                 in_word_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      sbs_pkg::res_t                 out_word_o
);
  import sbs_pkg::*;

  logic [COUNT_W-1:0]       count_q;
  logic [31:0]              n_eff;
  logic                     in_acc;
  logic                     busy;
  wr_t                      wr;
  probe_t                   chain   [NUM_CELLS+1];
  logic signed [DATA_W-1:0] rd_chain [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]     cell_valid;
  probe_t                   fin;
  res_t                     res;
  logic                     res_v;
  logic                     out_valid_q;
  res_t                     out_q;
  logic                     skid_valid_q;
  res_t                     skid_q;
  logic                     out_free;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // clamp the count to the table
  always_comb begin
    n_eff = 32'(count_q);
    if (n_eff == 32'd0) n_eff = 32'd1;
    if (n_eff > 32'(DEPTH)) n_eff = 32'(DEPTH);
  end

  // input handshake: one word in flight
  assign in_stall_o = busy || skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // load words write every table copy
  always_comb begin
    wr.we   = in_acc && (in_word_i.kind == KIND_LOAD) &&
              (32'(in_word_i.slot) < 32'(DEPTH));
    wr.addr = ADDR_W'(in_word_i.slot);
    wr.data = in_word_i.value;
  end

  // fresh search state entering the row
  always_comb begin
    chain[0].valid  = in_acc && (in_word_i.kind == KIND_SEARCH);
    chain[0].probed = 1'b0;
    chain[0].phase  = PH_FIRST;
    chain[0].done   = 1'b0;
    chain[0].hit    = 1'b0;
    chain[0].pos    = '0;
    chain[0].lo     = '0;
    chain[0].hi     = ADDR_W'(n_eff - 32'd1);
    chain[0].addr   = '0;
    chain[0].key    = in_word_i.value;
    rd_chain[0]     = '0;
  end

  // row of probe cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sbs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_i         (wr),
      .prev_i       (chain[k]),
      .prev_rdata_i (rd_chain[k]),
      .state_o      (chain[k+1]),
      .rdata_o      (rd_chain[k+1])
    );
    assign cell_valid[k] = chain[k+1].valid;
  end

  assign busy = |cell_valid;

  // settle the last probe
  assign fin          = probe_resolve(chain[NUM_CELLS], rd_chain[NUM_CELLS]);
  assign res_v        = chain[NUM_CELLS].valid;
  assign res.found    = fin.hit;
  assign res.position = fin.hit ? POS_W'(fin.pos) : '0;

  // output register with skid stage
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_v;
      skid_valid_q <= 1'b0;
    end else if (res_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  `SBS_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full, output empty")
  `SBS_ASSERT(a_single_search, $onehot0(cell_valid), "more than one search in the row")
  `SBS_ASSERT(a_result_has_room, res_v |-> !skid_valid_q, "result arrived with skid full")
  `SBS_ASSERT(a_search_enters, (in_acc && in_word_i.kind == KIND_SEARCH) |=> busy,
              "accepted search did not enter the row")

endmodule

`default_nettype wire

// File: bench/sorted_table_binary_search_unit_checker.sv
// checker that predicts and compares the search results of the binary search unit
`timescale 1ns / 1ps

module sorted_table_binary_search_unit_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sbs_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire sbs_pkg::req_t               in_word_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire sbs_pkg::res_t               out_word_i,
  output      int                          fail_count_o,
  output      int                          pending_o,
  output      int                          results_o,
  output      int                          hits_o
);
  import sbs_pkg::*;

  // mirror of the table and of the entry count register
  logic signed [DATA_W-1:0] entry_mirror [DEPTH];
  logic [COUNT_W-1:0]       count_mirror;
  res_t                     answers_due [$];
  res_t                     want;
  int                       fails;
  int                       results;
  int                       hits;

  // probe order: first entry, last entry, then bisection of the open span
  function automatic res_t predict_search(logic signed [DATA_W-1:0] key);
    res_t ans;
    int   n;
    int   lo;
    int   hi;
    int   mid;
    ans = '0;
    n = int'(count_mirror);
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    lo = 0;
    hi = n - 1;
    if (entry_mirror[lo] == key) begin
      ans.found    = 1'b1;
      ans.position = POS_W'(lo);
      return ans;
    end
    if (entry_mirror[hi] == key) begin
      ans.found    = 1'b1;
      ans.position = POS_W'(hi);
      return ans;
    end
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (entry_mirror[mid] == key) begin
        ans.found    = 1'b1;
        ans.position = POS_W'(mid);
        return ans;
      end
      if (entry_mirror[mid] > key) hi = mid;
      else lo = mid;
    end
    // not found leaves position at zero
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    fails++;
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mirror = COUNT_W'(1);
      answers_due.delete();
      fails   = 0;
      results = 0;
      hits    = 0;
    end else begin
      if (cfg_we_i) count_mirror = cfg_wdata_i;
      // input word: a load updates the mirror, a search queues its answer
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.kind == KIND_LOAD) entry_mirror[in_word_i.slot] = in_word_i.value;
        else answers_due.push_back(predict_search(in_word_i.value));
      end
      // result word against the oldest answer due
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result word with no search waiting: found %0b position %0d",
                                    out_word_i.found, out_word_i.position));
        end else begin
          want = answers_due.pop_front();
          if (want.found) hits++;
          if (out_word_i.found !== want.found)
            report_mismatch($sformatf("found flag is %0b, expected %0b",
                                      out_word_i.found, want.found));
          if (out_word_i.position !== want.position)
            report_mismatch($sformatf("position is %0d, expected %0d",
                                      out_word_i.position, want.position));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= answers_due.size();
    results_o    <= results;
    hits_o       <= hits;
  end

endmodule

// File: bench/sorted_table_binary_search_unit_tb.sv
// stimulus and verdict for the sorted table binary search unit
`timescale 1ns / 1ps

module sorted_table_binary_search_unit_tb;
  import sbs_pkg::*;

  localparam int ITEM_TARGET   = 1300;
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int COUNT_MAX     = 2 ** COUNT_W - 1;
  localparam logic signed [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

  typedef enum int {TABLE_WIDE, TABLE_DENSE, TABLE_SCRAMBLED} table_style_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  req_t               in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  res_t               out_word;

  logic stall_en     = 1'b0;
  bit   send_idle_en = 1'b0;
  int   stall_hold   = 0;
  int   cycles       = 0;
  int   fail_count;
  int   pending;
  int   results;
  int   hits;
  int   loads_sent    = 0;
  int   searches_sent = 0;
  int   sizes_tried   = 0;
  int   live_count    = 1;
  logic signed [DATA_W-1:0] entry_copy [DEPTH];

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_table_binary_search_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  sorted_table_binary_search_unit_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits)
  );

  // mostly short idle runs, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls in random runs while enabled
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= stall_en && ($urandom_range(0, 1) == 1);
      stall_hold <= idle_length();
    end
  end

  // present one word and hold it until accepted
  task automatic send_word(logic word_kind, logic [SLOT_W-1:0] slot,
                           logic signed [DATA_W-1:0] value);
    req_t w;
    int   gap;
    w.kind  = word_kind;
    w.slot  = slot;
    w.value = value;
    gap = send_idle_en ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (word_kind == KIND_LOAD) begin
      entry_copy[slot] = value;
      loads_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  // sender holds off until every search has answered, then the block settles
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int count);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_count = (count < 1) ? 1 : (count > DEPTH) ? DEPTH : count;
    sizes_tried++;
  endtask

  // fill slots 0..n-1, ascending unless scrambled
  task automatic load_table(int n, table_style_e style);
    longint span;
    longint cur;
    if (style == TABLE_WIDE) begin
      span = (longint'(1) << 32) / n;
      cur  = -(longint'(1) << 31) + longint'($urandom) % span;
    end else begin
      span = 4;
      cur  = -(longint'(1) << 31) + longint'($urandom) % ((longint'(1) << 32) - 1024);
    end
    for (int i = 0; i < n; i++) begin
      if (style == TABLE_SCRAMBLED) begin
        send_word(KIND_LOAD, SLOT_W'(i), $urandom);
      end else begin
        send_word(KIND_LOAD, SLOT_W'(i), DATA_W'(cur));
        cur += (style == TABLE_WIDE) ? 1 + longint'($urandom) % span
                                     : longint'($urandom_range(0, 3));
      end
    end
  endtask

  // keys: mostly table hits, then near misses, random values and the extremes
  function automatic logic signed [DATA_W-1:0] pick_key();
    int idx;
    idx = $urandom_range(0, live_count - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return entry_copy[idx];
      5, 6:          return entry_copy[idx] + ($urandom_range(0, 1) ? 1 : -1);
      7:             return $urandom;
      8:             return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      default:       return $urandom_range(0, 1) ? entry_copy[0] - 1
                                                 : entry_copy[live_count - 1] + 1;
    endcase
  endfunction

  // one table size: set the count, refill the table, then mixed traffic
  task automatic run_phase(int count);
    table_style_e style;
    int           n_items;
    int           r;
    int           idx;
    write_count(count);
    stall_en     <= ($urandom_range(0, 3) != 0);
    send_idle_en = ($urandom_range(0, 3) != 0);
    r = $urandom_range(0, 9);
    style = (r == 0) ? TABLE_SCRAMBLED : (r < 5) ? TABLE_DENSE : TABLE_WIDE;
    load_table(live_count, style);
    n_items = $urandom_range(40, 100);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // overwrite with a neighbor value, order kept
        idx = $urandom_range(0, live_count - 1);
        send_word(KIND_LOAD, SLOT_W'(idx), entry_copy[(idx > 0) ? idx - 1 : idx]);
      end else if (r == 1) begin
        // stray load, may break the order
        send_word(KIND_LOAD, SLOT_W'($urandom_range(0, DEPTH - 1)), $urandom);
      end else begin
        send_word(KIND_SEARCH, SLOT_W'($urandom), pick_key());
      end
    end
  endtask

  initial begin
    int count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: value extremes and the top slot
    send_word(KIND_LOAD, SLOT_W'(0), KEY_MIN);
    send_word(KIND_LOAD, SLOT_W'(1), -1);
    send_word(KIND_LOAD, SLOT_W'(2), 0);
    send_word(KIND_LOAD, SLOT_W'(3), KEY_MAX);
    send_word(KIND_LOAD, SLOT_W'(DEPTH - 1), KEY_MAX);
    // single entry after reset: only entry 0 is compared
    send_word(KIND_SEARCH, SLOT_W'(0), KEY_MIN);
    send_word(KIND_SEARCH, SLOT_W'(DEPTH - 1), 0);
    // count of zero behaves as one
    write_count(0);
    send_word(KIND_SEARCH, SLOT_W'(0), KEY_MAX);
    send_word(KIND_SEARCH, SLOT_W'(0), KEY_MIN);
    // two entries: both ends only
    write_count(2);
    send_word(KIND_SEARCH, SLOT_W'(0), -1);
    send_word(KIND_SEARCH, SLOT_W'(0), 5);
    // four entries: bisection hit, last-entry hit and misses
    write_count(4);
    send_word(KIND_SEARCH, SLOT_W'(0), 0);
    send_word(KIND_SEARCH, SLOT_W'(0), KEY_MAX);
    send_word(KIND_SEARCH, SLOT_W'(0), -3);
    send_word(KIND_SEARCH, SLOT_W'(0), 1);
    // unsorted table: probe path misses a key that is present
    send_word(KIND_LOAD, SLOT_W'(1), 100);
    send_word(KIND_SEARCH, SLOT_W'(0), 0);
    send_word(KIND_LOAD, SLOT_W'(1), -1);

    // largest counts first, then random sizes, mostly small
    run_phase(COUNT_MAX);
    run_phase(DEPTH);
    while (loads_sent + searches_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0:       count = 0;
        1:       count = 1;
        2:       count = 2;
        3:       count = DEPTH;
        4:       count = $urandom_range(DEPTH + 1, COUNT_MAX);
        13, 14, 15: count = $urandom_range(17, DEPTH - 1);
        default: count = $urandom_range(3, 16);
      endcase
      run_phase(count);
    end
    drain_results();

    $display("sent %0d load words and %0d search words over %0d table sizes",
             loads_sent, searches_sent, sizes_tried);
    $display("checked %0d result words, %0d of them hits", results, hits);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
